// File: src/olir_pkg.sv
`default_nettype none

package olir_pkg;

   localparam int CAPACITY_DEFAULT      = 16;
   localparam int ELEMENT_WIDTH_DEFAULT = 32;

   localparam int OPCODE_W   = 3;
   localparam int DATA_W     = 32;
   localparam int INDEX_W    = 5;
   localparam int TO_INDEX_W = 4;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;

   localparam logic [OPCODE_W-1:0] OP_APPEND      = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT      = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_MOVE        = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_REMOVE      = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_LAST = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_READ        = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd3;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic app;
      logic ins;
      logic mov_up;
      logic mov_dn;
      logic rem;
   } olir_ctrl_type;

endpackage

`default_nettype wire

// File: src/olir_req_if.sv
`default_nettype none

interface olir_req_if;
   import olir_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OPCODE_W-1:0]   opcode;
   logic [DATA_W-1:0]     element;
   logic [INDEX_W-1:0]    index;
   logic [TO_INDEX_W-1:0] to_index;

   modport source(output valid, output opcode, output element, output index,
                  output to_index, input ready);
   modport sink(input valid, input opcode, input element, input index,
                input to_index, output ready);
endinterface

`default_nettype wire

// File: src/olir_rsp_if.sv
`default_nettype none

interface olir_rsp_if;
   import olir_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   read_data;
   logic [COUNT_W-1:0]  entry_count;

   modport source(output valid, output status, output read_data,
                  output entry_count, input ready);
   modport sink(input valid, input status, input read_data,
                input entry_count, output ready);
endinterface

`default_nettype wire

// File: src/olir_cell.sv
`default_nettype none

module olir_cell #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int CMP_W         = 5,
   parameter int POSITION      = 0
) (
   input  logic                      clock,
   input  olir_pkg::olir_ctrl_type   ctrl,
   input  logic [CMP_W-1:0]          idx,
   input  logic [CMP_W-1:0]          dst,
   input  logic [CMP_W-1:0]          count,
   input  logic [ELEMENT_WIDTH-1:0]  new_data,
   input  logic [ELEMENT_WIDTH-1:0]  held_data,
   input  logic [ELEMENT_WIDTH-1:0]  left_data,
   input  logic [ELEMENT_WIDTH-1:0]  right_data,
   output logic [ELEMENT_WIDTH-1:0]  data,
   output logic [ELEMENT_WIDTH-1:0]  sel_data
);
   import olir_pkg::*;

   localparam logic [CMP_W-1:0] Pos     = CMP_W'(POSITION);
   localparam logic [CMP_W-1:0] PosNext = CMP_W'(POSITION + 1);

   logic [ELEMENT_WIDTH-1:0] data_ff;
   logic [ELEMENT_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.app) begin
         if (Pos == count) data_in = new_data;
      end else if (ctrl.ins) begin
         if (Pos == idx) data_in = new_data;
         else if (Pos > idx && Pos <= count) data_in = left_data;
      end else if (ctrl.mov_up) begin
         if (Pos == dst) data_in = held_data;
         else if (Pos >= idx && Pos < dst) data_in = right_data;
      end else if (ctrl.mov_dn) begin
         if (Pos == dst) data_in = held_data;
         else if (Pos > dst && Pos <= idx) data_in = left_data;
      end else if (ctrl.rem) begin
         if (Pos >= idx && PosNext < count) data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign sel_data = (Pos == idx) ? data_ff : '0;

endmodule

`default_nettype wire

// File: src/ordered_list_insert_remove_unit.sv
`default_nettype none

// Channel  Port      Dir  Payload
// request  req_chan  in   opcode, element, index, to_index
// result   rsp_chan  out  status, read_data, entry_count
//
// Each transfer passes through accept, select (the cell at index drives the
// shared select bus, status is evaluated) and apply (all cells shift at once).
// The apply cycle waits while the output register holds an untaken result.
// Synchronous reset empties the list; cell contents are not cleared.
// A new request is taken while the previous result waits at the output.

module ordered_list_insert_remove_unit #(
   parameter int CAPACITY      = olir_pkg::CAPACITY_DEFAULT,
   parameter int ELEMENT_WIDTH = olir_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   olir_req_if.sink    req_chan,
   olir_rsp_if.source  rsp_chan
);
   import olir_pkg::*;

   localparam int CountW = $clog2(CAPACITY + 1);
   localparam int CmpW   = (CountW > INDEX_W) ? CountW : INDEX_W;
   localparam int KeepW  = (ELEMENT_WIDTH < DATA_W) ? ELEMENT_WIDTH : DATA_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SEL   = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [OPCODE_W-1:0]      op_ff;
   logic [ELEMENT_WIDTH-1:0] elem_ff;
   logic [CmpW-1:0]          idx_ff;
   logic [CmpW-1:0]          dst_ff;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [ELEMENT_WIDTH-1:0] held_ff;
   logic [CountW-1:0]        count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [DATA_W-1:0]        rsp_data_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;

   logic                     req_fire;
   logic                     apply_fire;
   logic                     apply_ok;
   logic [CmpW-1:0]          count_ext;
   olir_ctrl_type            ctrl;
   logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
   logic [ELEMENT_WIDTH-1:0] sel_words [CAPACITY];
   logic [ELEMENT_WIDTH-1:0] sel_bus;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign apply_fire     = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_chan.ready);
   assign apply_ok       = apply_fire && (status_ff == ST_OK);
   assign count_ext      = CmpW'(count_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_SEL;
         S_SEL:   state_in = S_APPLY;
         S_APPLY: if (apply_fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      status_in = ST_OK;
      unique case (op_ff) inside
         OP_APPEND: begin
            if (elem_ff == '0) status_in = ST_ZERO;
            else if (count_ff >= CountW'(CAPACITY)) status_in = ST_FULL;
         end
         OP_INSERT: begin
            if (elem_ff == '0) status_in = ST_ZERO;
            else if (idx_ff > count_ext) status_in = ST_RANGE;
            else if (count_ff >= CountW'(CAPACITY)) status_in = ST_FULL;
         end
         OP_MOVE: begin
            if (idx_ff >= count_ext || dst_ff >= count_ext) status_in = ST_RANGE;
         end
         OP_REMOVE, OP_READ: begin
            if (idx_ff >= count_ext) status_in = ST_RANGE;
         end
         OP_REMOVE_LAST: begin
            if (count_ff == '0) status_in = ST_RANGE;
         end
         default: status_in = ST_OK;
      endcase
   end

   always_comb begin
      ctrl.app    = apply_ok && (op_ff == OP_APPEND);
      ctrl.ins    = apply_ok && (op_ff == OP_INSERT);
      ctrl.mov_up = apply_ok && (op_ff == OP_MOVE) && (dst_ff > idx_ff);
      ctrl.mov_dn = apply_ok && (op_ff == OP_MOVE) && (dst_ff < idx_ff);
      ctrl.rem    = apply_ok && (op_ff == OP_REMOVE);
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.app || ctrl.ins) count_in = count_ff + 1'b1;
      else if (apply_ok && (op_ff == OP_REMOVE || op_ff == OP_REMOVE_LAST))
         count_in = count_ff - 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_fire) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_comb begin
      sel_bus = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_bus = sel_bus | sel_words[i];
      end
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [ELEMENT_WIDTH-1:0] left_data;
         logic [ELEMENT_WIDTH-1:0] right_data;
         if (g == 0) begin : g_first
            assign left_data = '0;
         end else begin : g_mid_l
            assign left_data = cell_data[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign right_data = '0;
         end else begin : g_mid_r
            assign right_data = cell_data[g+1];
         end
         olir_cell #(
            .ELEMENT_WIDTH(ELEMENT_WIDTH),
            .CMP_W        (CmpW),
            .POSITION     (g)
         ) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .idx       (idx_ff),
            .dst       (dst_ff),
            .count     (count_ext),
            .new_data  (elem_ff),
            .held_data (held_ff),
            .left_data (left_data),
            .right_data(right_data),
            .data      (cell_data[g]),
            .sel_data  (sel_words[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_chan.opcode;
         elem_ff <= ELEMENT_WIDTH'(req_chan.element[KeepW-1:0]);
         idx_ff  <= CmpW'(req_chan.index);
         dst_ff  <= CmpW'(req_chan.to_index);
      end
      if (state_ff == S_SEL) begin
         status_ff <= status_in;
         held_ff   <= sel_bus;
      end
      if (apply_fire) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= (status_ff == ST_OK && op_ff == OP_READ) ?
                          DATA_W'(held_ff[KeepW-1:0]) : '0;
         rsp_count_ff  <= COUNT_W'(count_in);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.read_data   = rsp_data_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(CAPACITY))
      else $error("entry count above capacity");

   a_fail_holds_count: assert property (@(posedge clock) disable iff (reset)
      (apply_fire && status_ff != ST_OK) |=> $stable(count_ff))
      else $error("failed operation changed the count");

   a_remove_decrements: assert property (@(posedge clock) disable iff (reset)
      (apply_ok && (op_ff == OP_REMOVE || op_ff == OP_REMOVE_LAST))
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("remove did not decrement the count");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_APPLY)
      else $error("result raised outside apply");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import olir_pkg::*;

   localparam int LIST_DEPTH   = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 1070;

   // codes the block leaves undefined; they must act as no-ops
   localparam logic [OPCODE_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE7 = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   read_data;
      logic [COUNT_W-1:0]  entry_count;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   olir_req_if req_bus();
   olir_rsp_if rsp_bus();

   ordered_list_insert_remove_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   logic [DATA_W-1:0] list_words [LIST_DEPTH];
   int                list_count  = 0;
   list_result_type   result_q[$];
   int                error_count = 0;
   int                idle_pct    = 34;
   int                hold_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic list_result_type apply_list_op(input logic [OPCODE_W-1:0]   op,
                                                     input logic [DATA_W-1:0]     elem,
                                                     input logic [INDEX_W-1:0]    idx,
                                                     input logic [TO_INDEX_W-1:0] dst);
      list_result_type   res;
      logic [DATA_W-1:0] held;
      int                src_pos;
      int                dst_pos;
      res        = '0;
      res.status = ST_OK;
      src_pos    = idx;
      dst_pos    = dst;
      case (op)
         OP_APPEND: begin
            if (elem == '0) res.status = ST_ZERO;
            else if (list_count >= LIST_DEPTH) res.status = ST_FULL;
            else begin
               list_words[list_count] = elem;
               list_count++;
            end
         end
         OP_INSERT: begin
            if (elem == '0) res.status = ST_ZERO;
            else if (src_pos > list_count) res.status = ST_RANGE;
            else if (list_count >= LIST_DEPTH) res.status = ST_FULL;
            else begin
               for (int i = list_count; i > src_pos; i--) list_words[i] = list_words[i-1];
               list_words[src_pos] = elem;
               list_count++;
            end
         end
         OP_MOVE: begin
            if (src_pos >= list_count || dst_pos >= list_count) res.status = ST_RANGE;
            else if (src_pos != dst_pos) begin
               held = list_words[src_pos];
               if (dst_pos > src_pos) begin
                  for (int i = src_pos; i < dst_pos; i++) list_words[i] = list_words[i+1];
               end else begin
                  for (int i = src_pos; i > dst_pos; i--) list_words[i] = list_words[i-1];
               end
               list_words[dst_pos] = held;
            end
         end
         OP_REMOVE: begin
            if (src_pos >= list_count) res.status = ST_RANGE;
            else begin
               for (int i = src_pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
               list_count--;
            end
         end
         OP_REMOVE_LAST: begin
            if (list_count == 0) res.status = ST_RANGE;
            else list_count--;
         end
         OP_READ: begin
            if (src_pos >= list_count) res.status = ST_RANGE;
            else res.read_data = list_words[src_pos];
         end
         default: ;
      endcase
      res.entry_count = COUNT_W'(list_count);
      return res;
   endfunction

   task automatic report_result_error(input string what, input list_result_type want,
                                      input list_result_type seen);
      error_count++;
      if (error_count <= 10)
         $display("%0t %s: expected status=%0d data=%h count=%0d, got status=%0d data=%h count=%0d",
                  $time, what, want.status, want.read_data, want.entry_count,
                  seen.status, seen.read_data, seen.entry_count);
   endtask

   // result side: compare each transfer against the oldest prediction
   always @(posedge clock) begin
      list_result_type seen;
      list_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.status      = rsp_bus.status;
         seen.read_data   = rsp_bus.read_data;
         seen.entry_count = rsp_bus.entry_count;
         if (result_q.size() == 0) begin
            report_result_error("unexpected transfer", '0, seen);
         end else begin
            want = result_q.pop_front();
            if (seen.status !== want.status || seen.read_data !== want.read_data ||
                seen.entry_count !== want.entry_count)
               report_result_error("mismatch", want, seen);
         end
      end
   end

   // result side ready: random stalls, or a counted hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready = 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_bus.ready = 1'b0;
         hold_cycles   = hold_cycles - 1;
      end else begin
         rsp_bus.ready = ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input logic [OPCODE_W-1:0]   op,
                            input logic [DATA_W-1:0]     elem,
                            input logic [INDEX_W-1:0]    idx,
                            input logic [TO_INDEX_W-1:0] dst);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.opcode   = op;
      req_bus.element  = elem;
      req_bus.index    = idx;
      req_bus.to_index = dst;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      result_q.push_back(apply_list_op(op, elem, idx, dst));
      @(negedge clock);
   endtask

   task automatic wait_results_drained();
      req_bus.valid = 1'b0;
      while (result_q.size() != 0) @(negedge clock);
   endtask

   task automatic test_empty_list();
      send_item(OP_REMOVE_LAST, 32'h0000_0007, 5'd0, 4'd0);
      send_item(OP_READ, '0, 5'd0, 4'd0);
      send_item(OP_REMOVE, '0, 5'd0, 4'd0);
      send_item(OP_MOVE, '0, 5'd0, 4'd0);
      send_item(OP_INSERT, 32'h0000_0005, 5'd1, 4'd0);
      send_item(OP_APPEND, '0, 5'd0, 4'd0);
      // zero element wins over a bad index
      send_item(OP_INSERT, '0, 5'd16, 4'd0);
      send_item(OP_SPARE6, '1, 5'd16, 4'd15);
      send_item(OP_SPARE7, 32'h1234_5678, 5'd3, 4'd9);
   endtask

   task automatic test_fill_to_capacity();
      send_item(OP_APPEND, '1, 5'd0, 4'd0);
      send_item(OP_INSERT, 32'h0000_0001, 5'd0, 4'd0);
      for (int i = 2; i < LIST_DEPTH; i++)
         send_item(OP_INSERT, 32'h8000_0000 | i, (i % 3 == 0) ? INDEX_W'(i) : INDEX_W'(i / 2),
                   4'd0);
      send_item(OP_APPEND, 32'hA5A5_A5A5, 5'd0, 4'd0);
      send_item(OP_INSERT, 32'h0000_0001, 5'd16, 4'd0);
   endtask

   task automatic test_move_remove_read();
      send_item(OP_MOVE, '0, 5'd0, 4'd15);
      send_item(OP_MOVE, '0, 5'd15, 4'd0);
      send_item(OP_MOVE, '0, 5'd7, 4'd7);
      send_item(OP_READ, '0, 5'd15, 4'd0);
      send_item(OP_READ, '0, 5'd16, 4'd0);
      send_item(OP_REMOVE, '0, 5'd0, 4'd0);
      send_item(OP_REMOVE_LAST, '0, 5'd0, 4'd0);
      send_item(OP_INSERT, 32'h0000_0002, 5'd16, 4'd0);
      send_item(OP_MOVE, '0, 5'd14, 4'd3);
   endtask

   task automatic test_output_backpressure();
      hold_cycles = 120;
      for (int i = 0; i < 24; i++) begin
         if (i % 2 == 0 && list_count > 0)
            send_item(OP_READ, '0, INDEX_W'($urandom_range(0, list_count - 1)), 4'd0);
         else if (list_count < LIST_DEPTH)
            send_item(OP_APPEND, $urandom() | 32'h1, 5'd0, 4'd0);
         else
            send_item(OP_REMOVE, '0, INDEX_W'($urandom_range(0, LIST_DEPTH - 1)), 4'd0);
      end
   endtask

   task automatic test_random_ops(input int n_items);
      logic [OPCODE_W-1:0]   op;
      logic [DATA_W-1:0]     elem;
      logic [INDEX_W-1:0]    idx;
      logic [TO_INDEX_W-1:0] dst;
      int                    sel;
      int                    grow_pct;
      grow_pct = 45;
      for (int k = 0; k < n_items; k++) begin
         if (k % 100 == 0) grow_pct = (k % 200 == 0) ? 45 : 20;
         if (k == n_items / 2) idle_pct = 0;
         if (k == n_items / 2 + 200) idle_pct = 34;
         case ($urandom_range(0, 31))
            0:       elem = '0;
            1:       elem = '1;
            2:       elem = 32'h0000_0001;
            default: elem = $urandom();
         endcase
         idx = (list_count == 0) ? '0 : INDEX_W'($urandom_range(0, list_count - 1));
         dst = (list_count == 0) ? '0 : TO_INDEX_W'($urandom_range(0, list_count - 1));
         sel = $urandom_range(0, 99);
         if (sel < grow_pct) begin
            op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
            if (op == OP_INSERT) idx = INDEX_W'($urandom_range(0, list_count));
         end else if (sel < grow_pct + 22) begin
            op = $urandom_range(0, 1) ? OP_REMOVE : OP_REMOVE_LAST;
         end else if (sel < grow_pct + 40) begin
            op = OP_MOVE;
         end else if (sel < 94) begin
            op = OP_READ;
         end else begin
            // noise: any code, any index from 0 to 16
            op  = OPCODE_W'($urandom_range(0, 7));
            idx = INDEX_W'($urandom_range(0, 16));
            dst = TO_INDEX_W'($urandom());
         end
         send_item(op, elem, idx, dst);
      end
   endtask

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.opcode   = OP_APPEND;
      req_bus.element  = '0;
      req_bus.index    = '0;
      req_bus.to_index = '0;
      rsp_bus.ready    = 1'b0;
      for (int i = 0; i < LIST_DEPTH; i++) list_words[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_list();
      wait_results_drained();
      test_fill_to_capacity();
      wait_results_drained();
      test_move_remove_read();
      wait_results_drained();
      test_output_backpressure();
      wait_results_drained();
      test_random_ops(RANDOM_ITEMS);
      req_bus.valid = 1'b0;

      for (int n = 0; n < 5000 && result_q.size() != 0; n++) @(negedge clock);
      repeat (12) @(negedge clock);
      if (error_count == 0 && result_q.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
